@@ rtl/m3i_pkg.sv @@
// Shared constants and types for the 3x3 matrix inverse unit.
package m3i_pkg;

  // Number of elements in one 3x3 matrix.
  localparam int NUM_ELEM = 9;

  // Status carried with each result.
  typedef struct packed {
    logic singular;
    logic overflow;
  } m3i_flags_t;

  // Row-major index of element (row, col), rows and columns taken mod 3.
  function automatic int elem_idx(input int row, input int col);
    elem_idx = ((row % 3) * 3) + (col % 3);
  endfunction

endpackage

@@ rtl/m3i_if.sv @@
// Valid/ready channel interfaces for the matrix and inverse transactions.
interface m3i_mat_in_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface m3i_mat_out_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;
  logic                singular;
  logic                overflow;

  modport source (output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22, singular,
                  overflow, input ready);
  modport sink   (input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22, singular,
                  overflow, output ready);
endinterface

@@ rtl/m3i_front.sv @@
// Cofactor and determinant pipeline: five stages ahead of the divider lanes.
module m3i_front
  import m3i_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic [4:0]            en,
  input  logic signed [W-1:0]   a_in  [NUM_ELEM],
  output logic signed [W-1:0]   a_o   [NUM_ELEM],
  output logic signed [2*W:0]   cof_o [NUM_ELEM],
  output logic signed [3*W+1:0] det_o
);

  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 2;

  logic signed [W-1:0]    a0_r [NUM_ELEM];
  logic signed [W-1:0]    a1_r [NUM_ELEM];
  logic signed [W-1:0]    a2_r [NUM_ELEM];
  logic signed [W-1:0]    a3_r [NUM_ELEM];
  logic signed [W-1:0]    a4_r [NUM_ELEM];
  logic signed [2*W-1:0]  p0_r [NUM_ELEM];
  logic signed [2*W-1:0]  p1_r [NUM_ELEM];
  logic signed [CW-1:0]   c2_r [NUM_ELEM];
  logic signed [CW-1:0]   c3_r [NUM_ELEM];
  logic signed [CW-1:0]   c4_r [NUM_ELEM];
  logic signed [CW-1:0]   dlo_r [3];
  logic signed [CW-1:0]   dhi_r [3];
  logic signed [DW-1:0]   det_r;
  logic signed [DW-1:0]   det_nxt;

  // Stage 0 captures the matrix; later stages carry it alongside.
  always_ff @(posedge clk) begin
    if (en[0]) a0_r <= a_in;
    if (en[1]) a1_r <= a0_r;
    if (en[2]) a2_r <= a1_r;
    if (en[3]) a3_r <= a2_r;
    if (en[4]) a4_r <= a3_r;
    if (en[3]) c3_r <= c2_r;
    if (en[4]) c4_r <= c3_r;
  end

  // Stages 1 and 2: the two products of each 2x2 minor, then their difference.
  for (genvar e = 0; e < NUM_ELEM; e++) begin : g_cof
    localparam int R = e / 3;
    localparam int C = e % 3;
    always_ff @(posedge clk) begin
      if (en[1]) begin
        p0_r[e] <= a0_r[elem_idx(R + 1, C + 1)] * a0_r[elem_idx(R + 2, C + 2)];
        p1_r[e] <= a0_r[elem_idx(R + 1, C + 2)] * a0_r[elem_idx(R + 2, C + 1)];
      end
      if (en[2]) c2_r[e] <= CW'(p0_r[e]) - CW'(p1_r[e]);
    end
  end

  // Stage 3: each first-row term split into two narrower products.
  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      if (en[3]) begin
        dlo_r[j] <= a2_r[j] * $signed({1'b0, c2_r[j][W-1:0]});
        dhi_r[j] <= a2_r[j] * $signed(c2_r[j][CW-1:W]);
      end
    end
  end

  always_comb begin
    det_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      det_nxt = det_nxt + (DW'(dhi_r[j]) <<< W) + DW'(dlo_r[j]);
    end
  end

  // Stage 4: determinant sum.
  always_ff @(posedge clk) begin
    if (en[4]) det_r <= det_nxt;
  end

  assign a_o   = a4_r;
  assign cof_o = c4_r;
  assign det_o = det_r;

endmodule

@@ rtl/m3i_div_lane.sv @@
// One divider lane: rounded, saturated quotient of a cofactor by the determinant.
module m3i_div_lane
  import m3i_pkg::*;
#(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                  clk,
  input  logic [W+1:0]          en,
  input  logic signed [2*W:0]   cof,
  input  logic signed [3*W+1:0] det,
  output logic signed [W-1:0]   val,
  output logic                  sat
);

  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 2;
  localparam int XW = ((4 * W + 2) > (CW + 2 * F) ? (4 * W + 2) : (CW + 2 * F)) + 1;
  localparam int NS = W + 1;

  logic [XW-1:0] rem_r [NS];
  logic [DW-1:0] d_r   [NS];
  logic [W-1:0]  q_r   [NS];
  logic          neg_r [NS];
  logic          ovf_r [NS];
  logic signed [W-1:0] val_r;
  logic                sat_r;

  logic [CW-1:0] abs_c;
  logic [DW-1:0] abs_d;
  logic [W:0]    qr;
  logic          rnd;
  logic          over;

  assign abs_c = cof[CW-1] ? CW'(-cof) : CW'(cof);
  assign abs_d = det[DW-1] ? DW'(-det) : DW'(det);

  // Pre-stage: scaled numerator, and a quotient of 2^W or more flagged at once.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= XW'(abs_c) << (2 * F);
      d_r[0]   <= abs_d;
      q_r[0]   <= '0;
      neg_r[0] <= cof[CW-1] ^ det[DW-1];
      ovf_r[0] <= (XW'(abs_c) << (2 * F)) >= (XW'(abs_d) << W);
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 1; s < NS; s++) begin : g_bit
    localparam int K = W - s;
    logic ge;
    assign ge = rem_r[s-1] >= (XW'(d_r[s-1]) << K);
    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s] <= ge ? rem_r[s-1] - (XW'(d_r[s-1]) << K) : rem_r[s-1];
        q_r[s]   <= q_r[s-1] | (ge ? (W'(1) << K) : '0);
        d_r[s]   <= d_r[s-1];
        neg_r[s] <= neg_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
      end
    end
  end

  // Round half away from zero on the magnitude, then apply sign and clamp.
  assign rnd  = {rem_r[NS-1], 1'b0} >= (XW + 1)'(d_r[NS-1]);
  assign qr   = {1'b0, q_r[NS-1]} + (W + 1)'(rnd);
  assign over = ovf_r[NS-1] ||
                (neg_r[NS-1] ? (qr > ((W + 1)'(1) << (W - 1)))
                             : (qr >= ((W + 1)'(1) << (W - 1))));

  always_ff @(posedge clk) begin
    if (en[NS]) begin
      sat_r <= over;
      if (over) val_r <= neg_r[NS-1] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
      else      val_r <= neg_r[NS-1] ? $signed(-qr[W-1:0]) : $signed(qr[W-1:0]);
    end
  end

  assign val = val_r;
  assign sat = sat_r;

endmodule

@@ rtl/m3i_merge.sv @@
// Merge of the nine lane results into one inverse transaction with its flags.
module m3i_merge
  import m3i_pkg::*;
#(
  parameter int W = 32
) (
  input  logic signed [W-1:0] lane_val [NUM_ELEM],
  input  logic [NUM_ELEM-1:0] lane_sat,
  input  logic signed [W-1:0] a_orig   [NUM_ELEM],
  input  logic                det_zero,
  output logic signed [W-1:0] b        [NUM_ELEM],
  output m3i_flags_t          flags
);

  // A singular matrix is passed back untouched.
  always_comb begin
    for (int e = 0; e < NUM_ELEM; e++) begin
      b[e] = det_zero ? a_orig[e] : lane_val[e];
    end
    flags.singular = det_zero;
    flags.overflow = !det_zero && (|lane_sat);
  end

endmodule

@@ rtl/matrix3_inverse_unit.sv @@
// Top level of the pipelined 3x3 fixed-point matrix inverse unit.
//
// This unit inverts one 3x3 matrix of signed fixed-point elements (ELEM_WIDTH bits,
// FRAC_BITS fraction bits) per transaction by the adjugate method. The cofactors and the
// determinant are formed exactly, and nine divider lanes, one per element of the
// inverse, each divide a transposed cofactor by the determinant, round to nearest with
// ties away from zero and clamp to the element range, raising overflow when any element
// is clamped. A zero determinant returns the input matrix unchanged with singular set.
// The pipeline accepts a new matrix every clock cycle unless it is full and stalled,
// and it is made up of five cofactor and determinant stages,
// one divider set-up stage, one restoring divider stage per quotient bit, one rounding
// stage and the output register. Each stage holds its contents only while the stage
// after it is full and stalled, so empty slots are filled while a finished result
// waits on the output, and input ready falls only when every stage is occupied.
module matrix3_inverse_unit
  import m3i_pkg::*;
#(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  m3i_mat_in_if.sink    in_ch,
  m3i_mat_out_if.source out_ch
);

  localparam int W  = ELEM_WIDTH;
  localparam int LS = W + 2;       // divider lane stages
  localparam int L  = LS + 6;      // front stages, lane stages, output register

  logic [L-1:0] v_r;
  logic [L-1:0] v_nxt;
  logic [L-1:0] en;

  logic signed [W-1:0]     a_in   [NUM_ELEM];
  logic signed [W-1:0]     a_f    [NUM_ELEM];
  logic signed [2*W:0]     cof_f  [NUM_ELEM];
  logic signed [3*W+1:0]   det_f;
  logic signed [W-1:0]     lane_val [NUM_ELEM];
  logic [NUM_ELEM-1:0]     lane_sat;
  logic signed [W-1:0]     a_d_r  [LS][NUM_ELEM];
  logic [LS-1:0]           zero_d_r;
  logic signed [W-1:0]     b_nxt  [NUM_ELEM];
  logic signed [W-1:0]     b_r    [NUM_ELEM];
  m3i_flags_t              flags_nxt;
  m3i_flags_t              flags_r;

  // A stage may load when it is empty or when the stage after it is moving.
  always_comb begin
    en[L-1] = !v_r[L-1] || out_ch.ready;
    for (int k = L - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    for (int k = 0; k < L; k++) begin
      if (en[k]) v_nxt[k] = (k == 0) ? in_ch.valid : v_r[(k == 0) ? 0 : k - 1];
      else       v_nxt[k] = v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready = en[0];

  assign a_in[0] = in_ch.a00;
  assign a_in[1] = in_ch.a01;
  assign a_in[2] = in_ch.a02;
  assign a_in[3] = in_ch.a10;
  assign a_in[4] = in_ch.a11;
  assign a_in[5] = in_ch.a12;
  assign a_in[6] = in_ch.a20;
  assign a_in[7] = in_ch.a21;
  assign a_in[8] = in_ch.a22;

  m3i_front #(.W(W)) u_front (
    .clk   (clk),
    .en    (en[4:0]),
    .a_in  (a_in),
    .a_o   (a_f),
    .cof_o (cof_f),
    .det_o (det_f)
  );

  // Element (i, j) of the inverse is cofactor (j, i) over the determinant.
  for (genvar e = 0; e < NUM_ELEM; e++) begin : g_lane
    m3i_div_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk (clk),
      .en  (en[LS+4:5]),
      .cof (cof_f[elem_idx(e % 3, e / 3)]),
      .det (det_f),
      .val (lane_val[e]),
      .sat (lane_sat[e])
    );
  end

  // The original matrix and the zero-determinant flag travel beside the lanes.
  for (genvar s = 0; s < LS; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en[5+s]) begin
        if (s == 0) begin
          a_d_r[s]    <= a_f;
          zero_d_r[s] <= (det_f == '0);
        end else begin
          a_d_r[s]    <= a_d_r[(s == 0) ? 0 : s - 1];
          zero_d_r[s] <= zero_d_r[(s == 0) ? 0 : s - 1];
        end
      end
    end
  end

  m3i_merge #(.W(W)) u_merge (
    .lane_val (lane_val),
    .lane_sat (lane_sat),
    .a_orig   (a_d_r[LS-1]),
    .det_zero (zero_d_r[LS-1]),
    .b        (b_nxt),
    .flags    (flags_nxt)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (en[L-1]) begin
      b_r     <= b_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign out_ch.valid    = v_r[L-1];
  assign out_ch.b00      = b_r[0];
  assign out_ch.b01      = b_r[1];
  assign out_ch.b02      = b_r[2];
  assign out_ch.b10      = b_r[3];
  assign out_ch.b11      = b_r[4];
  assign out_ch.b12      = b_r[5];
  assign out_ch.b20      = b_r[6];
  assign out_ch.b21      = b_r[7];
  assign out_ch.b22      = b_r[8];
  assign out_ch.singular = flags_r.singular;
  assign out_ch.overflow = flags_r.overflow;

  // A singular result never reports overflow.
  a_sing_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.singular |-> !out_ch.overflow)
    else $error("singular transaction reports overflow");

  // Input is refused only when the whole pipeline is full and the output is stalled.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r) && !out_ch.ready)
    else $error("input refused while a pipeline stage is free");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && (v_r == '0))
    else $error("pipeline not empty after reset");

endmodule

@@ dv/matrix3_inverse_unit_tb.sv @@
// Self-checking testbench for the pipelined 3x3 fixed-point matrix inverse unit.
`timescale 1ns / 1ps

module matrix3_inverse_unit_tb;
  import m3i_pkg::*;

  localparam int W      = 32;
  localparam int F      = 16;
  localparam int LATENCY = W + 8;
  localparam logic signed [W-1:0] ONE = 32'sh0001_0000;

  typedef logic signed [W-1:0] elem_t;
  typedef logic signed [255:0] wide_t;

  typedef struct {
    elem_t a[NUM_ELEM];
  } matrix_t;

  typedef struct {
    elem_t b[NUM_ELEM];
    logic  singular;
    logic  overflow;
  } inverse_t;

  // The scoreboard works out the inverse of every accepted matrix and keeps the
  // answers in order of acceptance, since the unit returns them in that order.
  class inverse_scoreboard;
    inverse_t pending_inverses[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // Exact adjugate inverse: cofactors and determinant in wide arithmetic, each
    // quotient rounded on its magnitude with ties away from zero, then clamped.
    function inverse_t predict_inverse(matrix_t m);
      wide_t    el[3][3];
      wide_t    cof[3][3];
      wide_t    det, det_mag, mag, quot, rem;
      wide_t    limit;
      logic     neg;
      inverse_t r;
      r.singular = 1'b0;
      r.overflow = 1'b0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          el[i][j] = wide_t'(m.a[i*3+j]);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          cof[i][j] = el[(i+1)%3][(j+1)%3] * el[(i+2)%3][(j+2)%3]
                    - el[(i+1)%3][(j+2)%3] * el[(i+2)%3][(j+1)%3];
      det = el[0][0]*cof[0][0] + el[0][1]*cof[0][1] + el[0][2]*cof[0][2];
      if (det == 0) begin
        r.b = m.a;
        r.singular = 1'b1;
        return r;
      end
      det_mag = (det < 0) ? -det : det;
      limit = wide_t'(1) <<< (W - 1);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          neg  = (cof[j][i] < 0) != (det < 0);
          mag  = ((cof[j][i] < 0) ? -cof[j][i] : cof[j][i]) <<< (2 * F);
          quot = mag / det_mag;
          rem  = mag % det_mag;
          if ((rem <<< 1) >= det_mag) quot = quot + 1;
          if (!neg) begin
            if (quot >= limit) begin
              r.b[i*3+j] = {1'b0, {(W-1){1'b1}}};
              r.overflow = 1'b1;
            end else begin
              r.b[i*3+j] = quot[W-1:0];
            end
          end else begin
            if (quot > limit) begin
              r.b[i*3+j] = {1'b1, {(W-1){1'b0}}};
              r.overflow = 1'b1;
            end else begin
              r.b[i*3+j] = elem_t'(-quot);
            end
          end
        end
      return r;
    endfunction

    function void note_matrix(matrix_t m);
      pending_inverses.push_back(predict_inverse(m));
    endfunction

    function void check_inverse(inverse_t got);
      inverse_t want;
      if (pending_inverses.size() == 0) begin
        $display("%0t: inverse arrived with none outstanding", $time);
        errors++;
        return;
      end
      want = pending_inverses.pop_front();
      for (int k = 0; k < NUM_ELEM; k++)
        if (got.b[k] !== want.b[k]) begin
          $display("%0t: element %0d expected %h actual %h", $time, k, want.b[k], got.b[k]);
          errors++;
        end
      if (got.singular !== want.singular) begin
        $display("%0t: singular expected %b actual %b", $time, want.singular, got.singular);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  m3i_mat_in_if  #(.W(W)) in_ch ();
  m3i_mat_out_if #(.W(W)) out_ch ();

  matrix3_inverse_unit #(
    .ELEM_WIDTH(W),
    .FRAC_BITS (F)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  inverse_scoreboard sb = new();

  // Idle percentages for each side, changed between phases of the run.
  int send_idle_pct;
  int recv_stall_pct;
  // Cycles for which the receiver refuses every result regardless of the
  // stall percentage; it is counted down by the receiver process itself.
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous fixed limit on the length of the whole run.
  initial begin
    #4ms;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: checks the transaction completed at this edge, then decides
  // whether it will accept at the next one.
  always @(posedge clk) begin
    inverse_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.b = '{out_ch.b00, out_ch.b01, out_ch.b02, out_ch.b10, out_ch.b11, out_ch.b12,
                out_ch.b20, out_ch.b21, out_ch.b22};
      got.singular = out_ch.singular;
      got.overflow = out_ch.overflow;
      sb.check_inverse(got);
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offers one matrix, after a random number of idle cycles, and returns at the
  // edge where it is accepted. Valid is left high so that back-to-back
  // transactions need no second assignment in the same time step.
  task automatic send_matrix(input matrix_t m);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.a00 <= m.a[0]; in_ch.a01 <= m.a[1]; in_ch.a02 <= m.a[2];
    in_ch.a10 <= m.a[3]; in_ch.a11 <= m.a[4]; in_ch.a12 <= m.a[5];
    in_ch.a20 <= m.a[6]; in_ch.a21 <= m.a[7]; in_ch.a22 <= m.a[8];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_matrix(m);
  endtask

  task automatic drain_inverses();
    in_ch.valid <= 1'b0;
    while (sb.pending_inverses.size() != 0) @(posedge clk);
  endtask

  // Q16.16 value within about +/-8.0 with a random fraction.
  function automatic elem_t modest_elem();
    return elem_t'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
  endfunction

  // Random matrix of one of several shapes: well conditioned, full range,
  // tiny elements (inverses that saturate), or singular by a repeated or negated row.
  function automatic matrix_t random_matrix();
    matrix_t m;
    int      shape;
    shape = $urandom_range(0, 9);
    for (int k = 0; k < NUM_ELEM; k++) begin
      if (shape < 5)       m.a[k] = modest_elem();
      else if (shape < 7)  m.a[k] = elem_t'($urandom());
      else if (shape < 8)  m.a[k] = elem_t'($signed($urandom_range(0, 64)) - 32);
      else                 m.a[k] = modest_elem();
    end
    if (shape == 8) begin
      // Repeat a row, or scale one, so the determinant is exactly zero.
      for (int k = 0; k < 3; k++) m.a[6+k] = m.a[k];
    end else if (shape == 9) begin
      for (int k = 0; k < 3; k++) m.a[3+k] = elem_t'(-m.a[k]);
    end
    return m;
  endfunction

  function automatic matrix_t diag_matrix(elem_t d0, elem_t d1, elem_t d2);
    matrix_t m;
    m.a = '{d0, 0, 0, 0, d1, 0, 0, 0, d2};
    return m;
  endfunction

  task automatic run_phase(input int sidle, input int rstall, input int count);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    for (int n = 0; n < count; n++) begin
      send_matrix(random_matrix());
      // Occasional stretches with no idling at all.
      if ($urandom_range(0, 199) == 0) begin
        send_idle_pct = 0;
        repeat (20) send_matrix(random_matrix());
        send_idle_pct = sidle;
      end
    end
  endtask

  initial begin
    matrix_t m;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    out_ch.ready   = 1'b0;
    hold_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    {in_ch.a00, in_ch.a01, in_ch.a02, in_ch.a10, in_ch.a11, in_ch.a12,
     in_ch.a20, in_ch.a21, in_ch.a22} = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed matrices: identity, scaled and negative diagonals, the zero
    // matrix and a singular one with nonzero rows, extreme elements, and tiny
    // diagonals whose inverses must saturate in both directions.
    send_matrix(diag_matrix(ONE, ONE, ONE));
    send_matrix(diag_matrix(ONE <<< 1, ONE >>> 2, -ONE));
    send_matrix(diag_matrix(-ONE, -ONE, -ONE));
    send_matrix(diag_matrix(0, 0, 0));
    send_matrix(diag_matrix(1, 1, 1));
    send_matrix(diag_matrix(-1, 1, 3));
    send_matrix(diag_matrix(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_matrix(diag_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_matrix(diag_matrix(32'sh8000_0000, 32'sh7FFF_FFFF, ONE));
    send_matrix(diag_matrix(ONE <<< 1, ONE <<< 1, ONE <<< 1));
    send_matrix(diag_matrix(3 * ONE, 3 * ONE, 3 * ONE));
    m.a = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 9 * ONE};
    send_matrix(m);
    m.a = '{2 * ONE, 0, ONE, ONE, 3 * ONE, 0, 0, ONE, 4 * ONE};
    send_matrix(m);
    m.a = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};
    send_matrix(m);
    for (int k = 0; k < NUM_ELEM; k++) m.a[k] = 32'sh7FFF_FFFF;
    send_matrix(m);
    for (int k = 0; k < NUM_ELEM; k++) m.a[k] = 32'sh8000_0000;
    send_matrix(m);
    m.a = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh8000_0000, 0, 32'sh7FFF_FFFF};
    send_matrix(m);
    m.a = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
    send_matrix(m);
    drain_inverses();

    run_phase(0, 0, 380);
    run_phase(72, 0, 370);
    run_phase(0, 72, 370);
    run_phase(23, 23, 370);

    // Back pressure: the receiver refuses everything for a long stretch while
    // the sender keeps offering, so every stage fills and input ready falls.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 300;
    repeat (70) send_matrix(random_matrix());

    // Sender pauses until the pipeline has emptied completely.
    drain_inverses();
    repeat (20) send_matrix(random_matrix());

    drain_inverses();
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_inverses.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
